// ===== rtl/tidt_pkg.sv =====
`timescale 1ns / 1ps

package tidt_pkg;

    localparam int ENTRIES = 32;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W   = $clog2(ENTRIES + 1);

    localparam int ID_W    = 31;
    localparam int TIME_W  = 48;
    localparam int AGE_W   = 16;
    localparam int SLOT_W  = 5;
    localparam int STAT_W  = 2;
    localparam int OCNT_W  = 6;

    localparam logic [AGE_W-1:0] AGE_RESET = 16'd2000;

    localparam logic KIND_DETECT = 1'b0;
    localparam logic KIND_SWEEP  = 1'b1;

    typedef enum logic [STAT_W-1:0] {
        ST_MATCH  = 2'd0,
        ST_PLACED = 2'd1,
        ST_FULL   = 2'd2,
        ST_SWEEP  = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EVAL,
        S_COMMIT
    } t_state;

    // Request as broadcast to every cell of the row.
    typedef struct packed {
        logic              kind;
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] now;
        logic [AGE_W-1:0]  age;
    } t_op;

    typedef struct packed {
        logic eval;
        logic commit;
        logic any_hit;
    } t_ctl;

    typedef struct packed {
        logic hit;
        logic first_free;
        logic expire;
    } t_flags;

    function automatic logic [OCNT_W-1:0] sat_cnt(input logic [CNT_W-1:0] v);
        if (32'(v) > 32'd63) begin
            return 6'd63;
        end
        return OCNT_W'(v);
    endfunction

endpackage

// ===== rtl/tidt_cell.sv =====
`timescale 1ns / 1ps

module tidt_cell (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  tidt_pkg::t_op          i_op,
    input  tidt_pkg::t_ctl         i_ctl,
    input  logic                   i_free_before,
    output logic                   o_free_before,
    output tidt_pkg::t_flags       o_flags
);

    logic                            r_valid;
    logic [tidt_pkg::ID_W-1:0]       r_id;
    logic [tidt_pkg::TIME_W-1:0]     r_seen;
    tidt_pkg::t_flags                r_flags;
    tidt_pkg::t_flags                n_flags;
    logic [tidt_pkg::TIME_W:0]       w_deadline;

    // A free cell anywhere lower in the row blocks every free cell above it.
    assign o_free_before = i_free_before | ~r_valid;

    // Widened by one bit so that the sum never wraps.
    assign w_deadline = {1'b0, r_seen} + (tidt_pkg::TIME_W + 1)'(i_op.age);

    always_comb begin
        n_flags.hit        = r_valid && (r_id == i_op.id);
        n_flags.first_free = !r_valid && !i_free_before;
        n_flags.expire     = r_valid && (r_seen != i_op.now) &&
                             ({1'b0, i_op.now} > w_deadline);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.eval) begin
            r_flags <= n_flags;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctl.commit) begin
            if (i_op.kind == tidt_pkg::KIND_SWEEP) begin
                if (r_flags.expire) begin
                    r_valid <= 1'b0;
                end
            end else if (!i_ctl.any_hit && r_flags.first_free) begin
                r_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.commit && i_op.kind == tidt_pkg::KIND_DETECT) begin
            if (r_flags.hit) begin
                r_seen <= i_op.now;
            end else if (!i_ctl.any_hit && r_flags.first_free) begin
                r_id   <= i_op.id;
                r_seen <= i_op.now;
            end
        end
    end

    assign o_flags = r_flags;

endmodule

// ===== rtl/track_id_table_with_aging.sv =====
`timescale 1ns / 1ps
// A request is captured in S_IDLE, evaluated in S_EVAL and committed in S_COMMIT; the result is registered.
// A new request is taken only in S_IDLE, once the last one is committed; each takes one evaluate step and
// one commit step across the whole row of cells, and a stalled output holds the commit.
// Reset: all entries invalid, live count zero, age_limit 2000; no clearing pass,
// the block takes requests in the first cycle after reset.

module track_id_table_with_aging (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_kind,
    input  logic [tidt_pkg::ID_W-1:0]     i_object_id,
    input  logic [tidt_pkg::TIME_W-1:0]   i_frame_time,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [tidt_pkg::SLOT_W-1:0]   o_slot,
    output logic [tidt_pkg::STAT_W-1:0]   o_status,
    output logic [tidt_pkg::OCNT_W-1:0]   o_evicted,
    output logic [tidt_pkg::OCNT_W-1:0]   o_live_count,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [tidt_pkg::AGE_W-1:0]    i_cfg_data
);

    tidt_pkg::t_state                  r_state, n_state;
    tidt_pkg::t_op                     r_op, n_op;
    tidt_pkg::t_ctl                    w_ctl;
    logic [tidt_pkg::AGE_W-1:0]        r_age;
    logic [tidt_pkg::CNT_W-1:0]        r_live, n_live;

    logic                              r_out_valid, n_out_valid;
    logic [tidt_pkg::SLOT_W-1:0]       r_slot, n_slot;
    tidt_pkg::t_status                 r_status, n_status;
    logic [tidt_pkg::OCNT_W-1:0]       r_evicted, n_evicted;
    logic [tidt_pkg::OCNT_W-1:0]       r_live_out, n_live_out;

    logic [tidt_pkg::ENTRIES:0]        w_free_chain;
    tidt_pkg::t_flags                  w_flags [tidt_pkg::ENTRIES];
    logic [tidt_pkg::ENTRIES-1:0]      w_hit_vec, w_free_vec, w_exp_vec;
    logic [tidt_pkg::IDX_W-1:0]        w_hit_idx, w_free_idx;
    logic [tidt_pkg::CNT_W-1:0]        w_exp_cnt;
    logic                              w_any_hit, w_any_free;

    assign w_free_chain[0] = 1'b0;

    for (genvar g = 0; g < tidt_pkg::ENTRIES; g++) begin : g_cell
        tidt_cell u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_op          (r_op),
            .i_ctl         (w_ctl),
            .i_free_before (w_free_chain[g]),
            .o_free_before (w_free_chain[g+1]),
            .o_flags       (w_flags[g])
        );
        assign w_hit_vec[g]  = w_flags[g].hit;
        assign w_free_vec[g] = w_flags[g].first_free;
        assign w_exp_vec[g]  = w_flags[g].expire;
    end

    // Both vectors are one-hot or empty, so a plain OR of the indexes encodes them.
    always_comb begin
        w_hit_idx  = '0;
        w_free_idx = '0;
        for (int i = 0; i < tidt_pkg::ENTRIES; i++) begin
            if (w_hit_vec[i]) begin
                w_hit_idx = w_hit_idx | tidt_pkg::IDX_W'(i);
            end
            if (w_free_vec[i]) begin
                w_free_idx = w_free_idx | tidt_pkg::IDX_W'(i);
            end
        end
    end

    assign w_any_hit  = |w_hit_vec;
    assign w_any_free = |w_free_vec;
    assign w_exp_cnt  = tidt_pkg::CNT_W'($countones(w_exp_vec));

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_live      = r_live;
        n_out_valid = r_out_valid && i_out_stall;
        n_slot      = r_slot;
        n_status    = r_status;
        n_evicted   = r_evicted;
        n_live_out  = r_live_out;
        w_ctl.eval    = 1'b0;
        w_ctl.commit  = 1'b0;
        w_ctl.any_hit = w_any_hit;

        case (r_state)
            tidt_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_op.kind = i_kind;
                    n_op.id   = i_object_id;
                    n_op.now  = i_frame_time;
                    n_op.age  = r_age;
                    n_state   = tidt_pkg::S_EVAL;
                end
            end
            tidt_pkg::S_EVAL: begin
                w_ctl.eval = 1'b1;
                n_state    = tidt_pkg::S_COMMIT;
            end
            tidt_pkg::S_COMMIT: begin
                if (!r_out_valid || !i_out_stall) begin
                    w_ctl.commit = 1'b1;
                    n_out_valid  = 1'b1;
                    n_slot       = '0;
                    n_evicted    = '0;
                    if (r_op.kind == tidt_pkg::KIND_SWEEP) begin
                        n_status  = tidt_pkg::ST_SWEEP;
                        n_evicted = tidt_pkg::sat_cnt(w_exp_cnt);
                        n_live    = r_live - w_exp_cnt;
                    end else if (w_any_hit) begin
                        n_status = tidt_pkg::ST_MATCH;
                        n_slot   = tidt_pkg::SLOT_W'(w_hit_idx);
                    end else if (w_any_free) begin
                        n_status = tidt_pkg::ST_PLACED;
                        n_slot   = tidt_pkg::SLOT_W'(w_free_idx);
                        n_live   = r_live + tidt_pkg::CNT_W'(1);
                    end else begin
                        n_status = tidt_pkg::ST_FULL;
                    end
                    n_live_out = tidt_pkg::sat_cnt(n_live);
                    n_state    = tidt_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = tidt_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tidt_pkg::S_IDLE;
            r_live      <= '0;
            r_out_valid <= 1'b0;
            r_age       <= tidt_pkg::AGE_RESET;
        end else begin
            r_state     <= n_state;
            r_live      <= n_live;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid) begin
                r_age <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_slot     <= n_slot;
        r_status   <= n_status;
        r_evicted  <= n_evicted;
        r_live_out <= n_live_out;
    end

    assign o_in_stall   = (r_state != tidt_pkg::S_IDLE);
    assign o_cfg_ready  = 1'b1;
    assign o_out_valid  = r_out_valid;
    assign o_slot       = r_slot;
    assign o_status     = r_status;
    assign o_evicted    = r_evicted;
    assign o_live_count = r_live_out;

endmodule

// ===== rtl/tidt_checker.sv =====
`timescale 1ns / 1ps

module tidt_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          o_in_stall,
    input  logic                          o_out_valid,
    input  logic                          i_out_stall,
    input  logic [tidt_pkg::SLOT_W-1:0]   o_slot,
    input  logic [tidt_pkg::STAT_W-1:0]   o_status,
    input  logic [tidt_pkg::OCNT_W-1:0]   o_evicted,
    input  logic [tidt_pkg::OCNT_W-1:0]   o_live_count
);

    // A request accepted with no stalled result on the port finds out_valid low while it is in S_EVAL.
    a_no_early_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && !(o_out_valid && i_out_stall)) |=> !o_out_valid)
        else $error("result appeared one cycle after a request");

    // Sweeps and dropped detections carry slot zero.
    a_slot_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status == tidt_pkg::ST_SWEEP || o_status == tidt_pkg::ST_FULL))
        |-> (o_slot == '0))
        else $error("slot not zero for a sweep or a dropped detection");

    // Only a sweep frees entries.
    a_evict_sweep_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != tidt_pkg::ST_SWEEP) |-> (o_evicted == '0))
        else $error("entries freed by a detection");

    // A stalled result stays on the port unchanged.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
        (o_out_valid && $stable(o_status) && $stable(o_slot) && $stable(o_live_count)))
        else $error("stalled result changed");

endmodule

bind track_id_table_with_aging tidt_checker u_tidt_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .o_in_stall   (o_in_stall),
    .o_out_valid  (o_out_valid),
    .i_out_stall  (i_out_stall),
    .o_slot       (o_slot),
    .o_status     (o_status),
    .o_evicted    (o_evicted),
    .o_live_count (o_live_count)
);

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import tidt_pkg::*;

    localparam int QUIET_LIMIT = 5000;
    localparam int HOLD_CYCLES = 150;
    localparam logic [TIME_W-1:0] TIME_MAX = '1;

    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        t_status           status;
        logic [OCNT_W-1:0] evicted;
        logic [OCNT_W-1:0] live;
    } t_track_result;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_in_valid = 1'b0;
    logic              o_in_stall;
    logic              i_kind = KIND_DETECT;
    logic [ID_W-1:0]   i_object_id = '0;
    logic [TIME_W-1:0] i_frame_time = '0;
    logic              o_out_valid;
    logic              i_out_stall = 1'b0;
    logic [SLOT_W-1:0] o_slot;
    logic [STAT_W-1:0] o_status;
    logic [OCNT_W-1:0] o_evicted;
    logic [OCNT_W-1:0] o_live_count;
    logic              i_cfg_valid = 1'b0;
    logic              o_cfg_ready;
    logic [AGE_W-1:0]  i_cfg_data = '0;

    // Our own copy of the tracking table and the age register.
    logic              tbl_valid [ENTRIES];
    logic [ID_W-1:0]   tbl_id    [ENTRIES];
    logic [TIME_W-1:0] tbl_seen  [ENTRIES];
    int                live_total;
    logic [AGE_W-1:0]  age_limit_model;

    t_track_result expected_results[$];
    int            mismatches;
    int            send_idle_pct;
    int            recv_stall_pct;
    bit            hold_req;
    int            hold_left;
    int            quiet_cycles;

    track_id_table_with_aging i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_kind       (i_kind),
        .i_object_id  (i_object_id),
        .i_frame_time (i_frame_time),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_slot       (o_slot),
        .o_status     (o_status),
        .o_evicted    (o_evicted),
        .o_live_count (o_live_count),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    function automatic logic [OCNT_W-1:0] sat_count(input int v);
        return (v > 63) ? OCNT_W'(63) : OCNT_W'(v);
    endfunction

    function automatic t_track_result predict_track(input logic kind,
                                                    input logic [ID_W-1:0] id,
                                                    input logic [TIME_W-1:0] now);
        t_track_result res;
        int hit;
        int free_slot;
        int freed;
        res = '0;
        hit = -1;
        free_slot = -1;
        freed = 0;
        if (kind == KIND_DETECT) begin
            for (int i = 0; i < ENTRIES; i++) begin
                if (!tbl_valid[i]) begin
                    if (free_slot < 0) begin
                        free_slot = i;
                    end
                end else if (tbl_id[i] == id) begin
                    hit = i;
                    break;
                end
            end
            if (hit >= 0) begin
                tbl_seen[hit] = now;
                res.slot = SLOT_W'(hit);
                res.status = ST_MATCH;
            end else if (free_slot >= 0) begin
                tbl_valid[free_slot] = 1'b1;
                tbl_id[free_slot] = id;
                tbl_seen[free_slot] = now;
                live_total++;
                res.slot = SLOT_W'(free_slot);
                res.status = ST_PLACED;
            end else begin
                res.status = ST_FULL;
            end
        end else begin
            // The deadline is formed one bit wider so that it cannot wrap.
            for (int i = 0; i < ENTRIES; i++) begin
                if (tbl_valid[i] && tbl_seen[i] != now &&
                    (TIME_W+1)'(now) > (TIME_W+1)'(tbl_seen[i]) +
                                       (TIME_W+1)'(age_limit_model)) begin
                    tbl_valid[i] = 1'b0;
                    if (live_total > 0) begin
                        live_total--;
                    end
                    freed++;
                end
            end
            res.status = ST_SWEEP;
            res.evicted = sat_count(freed);
        end
        res.live = sat_count(live_total);
        return res;
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_request(input logic kind, input logic [ID_W-1:0] id,
                                input logic [TIME_W-1:0] now);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_kind <= kind;
        i_object_id <= id;
        i_frame_time <= now;
        do @(posedge i_clk); while (o_in_stall);
        expected_results.push_back(predict_track(kind, id, now));
        @(negedge i_clk);
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (expected_results.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    task automatic write_age_limit(input logic [AGE_W-1:0] age);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= age;
        do @(posedge i_clk); while (!o_cfg_ready);
        age_limit_model = age;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Runs on the reset value of the age limit: hits, lowest free slot,
    // the aging boundary, time going backwards and the top of the time range.
    task automatic test_reset_aging();
        send_request(KIND_DETECT, '0, '0);
        send_request(KIND_DETECT, '1, '0);
        send_request(KIND_DETECT, '0, '0);
        send_request(KIND_SWEEP, '0, '0);
        send_request(KIND_SWEEP, '0, TIME_W'(2000));
        send_request(KIND_DETECT, '0, TIME_W'(2001));
        send_request(KIND_SWEEP, '0, TIME_W'(2001));
        send_request(KIND_DETECT, ID_W'(5), TIME_W'(2001));
        send_request(KIND_SWEEP, '1, TIME_W'(100));
        send_request(KIND_DETECT, 31'h5555_5555, TIME_MAX);
        send_request(KIND_SWEEP, '0, TIME_MAX);
        send_request(KIND_DETECT, 31'h2AAA_AAAA, TIME_MAX - 5);
        send_request(KIND_SWEEP, '0, TIME_MAX);
    endtask

    task automatic test_table_full();
        logic [TIME_W-1:0] base;
        base = 48'h0000_1234_5678;
        wait_idle();
        write_age_limit(16'hFFFF);
        for (int k = 0; k < ENTRIES + 2; k++) begin
            send_request(KIND_DETECT, 31'h4000_0000 + ID_W'(k), base);
        end
        send_request(KIND_DETECT, 31'h4000_0000, base);
        send_request(KIND_SWEEP, '0, base + 65535);
        send_request(KIND_SWEEP, '0, base + 65536);
    endtask

    task automatic test_random_frames(input int count, input logic [AGE_W-1:0] age,
                                      input int send_pct, input int recv_pct,
                                      input bit pressure);
        logic [ID_W-1:0]   id_pool [48];
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] now;
        int                sent;
        int                n_det;
        int                pick;
        bit                pressed;
        wait_idle();
        send_idle_pct = send_pct;
        recv_stall_pct = recv_pct;
        write_age_limit(age);
        for (int k = 0; k < 48; k++) begin
            id_pool[k] = ID_W'($urandom);
        end
        if ($urandom_range(4) == 0) begin
            now = TIME_MAX - TIME_W'($urandom_range(200000));
        end else begin
            now = TIME_W'({$urandom, $urandom});
        end
        sent = 0;
        pressed = 1'b0;
        while (sent < count) begin
            if (pressure && !pressed && sent >= count / 2) begin
                hold_req = 1'b1;
                pressed = 1'b1;
            end
            if ($urandom_range(99) < 85) begin
                // A well-formed frame: up to six detections, then the sweep.
                n_det = $urandom_range(6);
                for (int d = 0; d < n_det; d++) begin
                    if ($urandom_range(9) == 0) begin
                        id = ID_W'($urandom);
                    end else begin
                        id = id_pool[$urandom_range(47)];
                    end
                    send_request(KIND_DETECT, id, now);
                end
                send_request(KIND_SWEEP, ID_W'($urandom), now);
                sent += n_det + 1;
                pick = $urandom_range(99);
                if (pick < 55) begin
                    now += TIME_W'($urandom_range(50));
                end else if (pick < 85) begin
                    now += TIME_W'(age_limit_model) + TIME_W'($urandom_range(2));
                end else if (pick < 95) begin
                    now += TIME_W'($urandom_range(200000));
                end else begin
                    now -= TIME_W'($urandom_range(1, 5000));
                end
            end else begin
                // Noise: a stray request off the frame's time.
                if ($urandom_range(1) == 0) begin
                    send_request(KIND_DETECT, id_pool[$urandom_range(47)],
                                 now + TIME_W'($urandom_range(3)));
                end else begin
                    send_request(KIND_SWEEP, ID_W'($urandom), TIME_W'({$urandom, $urandom}));
                end
                sent++;
            end
        end
    endtask

    always @(negedge i_clk) begin
        if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_track_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_results.size() == 0) begin
                $error("result with no request outstanding: slot %0d status %0d",
                       o_slot, o_status);
                mismatches++;
            end else begin
                want = expected_results.pop_front();
                if (o_slot !== want.slot) begin
                    $error("slot: expected %0d, got %0d", want.slot, o_slot);
                    mismatches++;
                end
                if (o_status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_status);
                    mismatches++;
                end
                if (o_evicted !== want.evicted) begin
                    $error("evicted: expected %0d, got %0d", want.evicted, o_evicted);
                    mismatches++;
                end
                if (o_live_count !== want.live) begin
                    $error("live_count: expected %0d, got %0d", want.live, o_live_count);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("testbench NOT OK");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        for (int i = 0; i < ENTRIES; i++) begin
            tbl_valid[i] = 1'b0;
            tbl_id[i] = '0;
            tbl_seen[i] = '0;
        end
        live_total = 0;
        age_limit_model = AGE_RESET;
        mismatches = 0;
        hold_req = 1'b0;
        hold_left = 0;
        quiet_cycles = 0;
        send_idle_pct = 37;
        recv_stall_pct = 63;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_aging();
        test_table_full();
        test_random_frames(230, 16'd0, 37, 63, 1'b1);
        test_random_frames(230, AGE_W'($urandom), 37, 63, 1'b0);
        test_random_frames(230, 16'd40, 63, 37, 1'b0);
        test_random_frames(230, 16'hFFFF, 63, 37, 1'b0);
        test_random_frames(230, 16'd2000, 0, 0, 1'b1);
        test_random_frames(230, AGE_W'($urandom_range(300)), 0, 0, 1'b0);

        wait_idle();
        repeat (8) @(posedge i_clk);
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule
